@@ design/lst_pkg.sv @@
package lst_pkg;

  // field widths of the stream beats
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned VAL_IN_W  = 32;
  localparam int unsigned EXT_W     = 64;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned OUT_W     = 16;

  // operation codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // outcome codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // strobes into the entry store
  typedef struct packed {
    logic rd_en;
    logic lnk_we;
    logic val_we;
  } lst_mem_ctl_t;

endpackage

@@ design/linked_set_table.sv @@
// channel | dir | tdata (low bit up)                       | tuser
// in_     | in  | value[31:0]                              | cmd[1:0]
// out_    | out | status[1:0] count[8:2] is_empty[9] 0[15:10] | -
//
// A search, a miss, a duplicate or a full add walks the list and answers;
// an add or remove that changes the list also passes S_ADD1, S_ADD2 or
// S_REM1, S_REM2. The walk visits 1..CAPACITY entries, one per cycle
// through the registered store read; an empty list skips it; the unused
// command gets a miss. After reset the link chain is rebuilt, in_tready low.
// One beat in flight; the next is taken while a result waits in the output
// register, and its result is held back until out_tready frees that register.
module linked_set_table #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lst_pkg::VAL_IN_W-1:0]  in_tdata,   // value[31:0]
  input  logic [lst_pkg::CMD_W-1:0]     in_tuser,   // cmd[1:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lst_pkg::OUT_W-1:0]     out_tdata   // status, count, is_empty, pad
);
  import lst_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(CAPACITY+1);
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_DECIDE, S_ADD1, S_ADD2, S_REM1, S_REM2, S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_idx_r, clr_idx_nxt;
  logic [PW-1:0]         head_r, head_nxt;
  logic [PW-1:0]         tail_r, tail_nxt;
  logic [PW-1:0]         free_r, free_nxt;
  logic [PW-1:0]         count_r, count_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;

  // per-beat working registers, no reset needed
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [PW-1:0]         cur_r, cur_nxt;
  logic [PW-1:0]         prev_r, prev_nxt;
  logic [PW-1:0]         succ_r, succ_nxt;
  logic [PW-1:0]         steps_r, steps_nxt;
  logic                  found_r, found_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [STATUS_W-1:0]   o_status_r, o_status_nxt;
  logic [CNT_W-1:0]      o_count_r, o_count_nxt;
  logic                  o_empty_r, o_empty_nxt;

  // store port
  lst_mem_ctl_t          mem_ctl;
  logic [AW-1:0]         rd_addr, lnk_waddr, val_waddr;
  logic [PW-1:0]         lnk_wdata, lnk_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [EXT_W-1:0]      in_ext;
  logic [PW+CNT_W-1:0]   cnt_ext;
  logic                  hit;

  assign in_ext  = {{(EXT_W-VAL_IN_W){in_tdata[VAL_IN_W-1]}}, in_tdata};
  assign cnt_ext = {{CNT_W{1'b0}}, count_r};
  assign hit     = (val_q == val_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_W-STATUS_W-CNT_W-1){1'b0}}, o_empty_r, o_count_r, o_status_r};

  lst_store #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .rd_addr   (rd_addr),
    .lnk_waddr (lnk_waddr),
    .lnk_wdata (lnk_wdata),
    .val_waddr (val_waddr),
    .val_wdata (val_r),
    .lnk_q     (lnk_q),
    .val_q     (val_q)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    succ_nxt       = succ_r;
    steps_nxt      = steps_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    o_status_nxt   = o_status_r;
    o_count_nxt    = o_count_r;
    o_empty_nxt    = o_empty_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mem_ctl        = '0;
    rd_addr        = '0;
    lnk_waddr      = '0;
    lnk_wdata      = '0;
    val_waddr      = '0;

    case (state_r)
      S_CLEAR: begin
        // rebuild the free chain: entry i links to i+1
        mem_ctl.lnk_we = 1'b1;
        lnk_waddr      = clr_idx_r;
        lnk_wdata      = PW'({1'b0, clr_idx_r}) + PW'(1);
        if (clr_idx_r == AW'(CAPACITY-1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          val_nxt   = in_ext[VALUE_BITS-1:0];
          cur_nxt   = head_r;
          prev_nxt  = NIL;
          steps_nxt = '0;
          found_nxt = 1'b0;
          if (in_tuser == CMD_ADD || in_tuser == CMD_REMOVE || in_tuser == CMD_SEARCH) begin
            if (head_r >= NIL) begin
              state_nxt = S_DECIDE;
            end else begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = head_r[AW-1:0];
              state_nxt     = S_WALK;
            end
          end else begin
            status_nxt = ST_MISS;
            state_nxt  = S_RESP;
          end
        end
      end
      S_WALK: begin
        // store output holds value and link of cur_r
        if (hit) begin
          found_nxt = 1'b1;
          succ_nxt  = lnk_q;
          state_nxt = S_DECIDE;
        end else if (lnk_q >= NIL || steps_r == PW'(CAPACITY-1)) begin
          state_nxt = S_DECIDE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = lnk_q[AW-1:0];
          prev_nxt      = cur_r;
          cur_nxt       = lnk_q;
          steps_nxt     = steps_r + PW'(1);
        end
      end
      S_DECIDE: begin
        case (cmd_r)
          CMD_ADD: begin
            if (found_r) begin
              status_nxt = ST_MISS;
              state_nxt  = S_RESP;
            end else if (count_r >= NIL || free_r >= NIL) begin
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = free_r[AW-1:0];
              state_nxt     = S_ADD1;
            end
          end
          CMD_REMOVE: begin
            if (found_r) begin
              state_nxt = S_REM1;
            end else begin
              status_nxt = ST_MISS;
              state_nxt  = S_RESP;
            end
          end
          default: begin
            status_nxt = found_r ? ST_OK : ST_MISS;
            state_nxt  = S_RESP;
          end
        endcase
      end
      S_ADD1: begin
        // pop the free head, fill the entry as the new tail
        free_nxt       = lnk_q;
        cur_nxt        = free_r;
        mem_ctl.lnk_we = 1'b1;
        lnk_waddr      = free_r[AW-1:0];
        lnk_wdata      = NIL;
        mem_ctl.val_we = 1'b1;
        val_waddr      = free_r[AW-1:0];
        state_nxt      = S_ADD2;
      end
      S_ADD2: begin
        if (head_r >= NIL) begin
          head_nxt = cur_r;
        end else if (tail_r < NIL) begin
          mem_ctl.lnk_we = 1'b1;
          lnk_waddr      = tail_r[AW-1:0];
          lnk_wdata      = cur_r;
        end
        tail_nxt   = cur_r;
        count_nxt  = count_r + PW'(1);
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
      end
      S_REM1: begin
        // unlink cur_r from its predecessor
        if (prev_r >= NIL) begin
          head_nxt = succ_r;
        end else begin
          mem_ctl.lnk_we = 1'b1;
          lnk_waddr      = prev_r[AW-1:0];
          lnk_wdata      = succ_r;
        end
        if (tail_r == cur_r) begin
          tail_nxt = prev_r;
        end
        state_nxt = S_REM2;
      end
      S_REM2: begin
        // push the entry onto the free list
        mem_ctl.lnk_we = 1'b1;
        lnk_waddr      = cur_r[AW-1:0];
        lnk_wdata      = free_r;
        free_nxt       = cur_r;
        if (count_r != '0) begin
          count_nxt = count_r - PW'(1);
        end
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          o_status_nxt   = status_r;
          o_count_nxt    = cnt_ext[CNT_W-1:0];
          o_empty_nxt    = (count_r == '0);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      head_r       <= NIL;
      tail_r       <= NIL;
      free_r       <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      free_r       <= free_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    succ_r     <= succ_nxt;
    steps_r    <= steps_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    o_status_r <= o_status_nxt;
    o_count_r  <= o_count_nxt;
    o_empty_r  <= o_empty_nxt;
  end

`ifndef SYNTH
  // element count never runs past the table size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NIL)
    else $error("element count above capacity");

  // between beats an empty list and a zero count go together
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((head_r >= NIL) == (count_r == '0)))
    else $error("list head and count disagree");

  // count moves only when an entry is linked in or released
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> ($past(state_r) == S_ADD2 || $past(state_r) == S_REM2))
    else $error("count changed outside add or remove");

  // one beat at a time: taking a beat drops ready
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second beat taken while busy");
`endif

endmodule

@@ design/lst_store.sv @@
module lst_store #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                            clk,
  input  lst_pkg::lst_mem_ctl_t           ctl,
  input  logic [$clog2(CAPACITY)-1:0]     rd_addr,
  input  logic [$clog2(CAPACITY)-1:0]     lnk_waddr,
  input  logic [$clog2(CAPACITY+1)-1:0]   lnk_wdata,
  input  logic [$clog2(CAPACITY)-1:0]     val_waddr,
  input  logic [VALUE_BITS-1:0]           val_wdata,
  output logic [$clog2(CAPACITY+1)-1:0]   lnk_q,
  output logic [VALUE_BITS-1:0]           val_q
);
  import lst_pkg::*;

  localparam int unsigned PW = $clog2(CAPACITY+1);

  logic [PW-1:0]         lnk_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];

  // links: one write, one registered read
  always_ff @(posedge clk) begin
    if (ctl.lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    if (ctl.rd_en) begin
      lnk_q <= lnk_mem[rd_addr];
    end
  end

  // values: no reset contents, only listed entries are compared
  always_ff @(posedge clk) begin
    if (ctl.val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (ctl.rd_en) begin
      val_q <= val_mem[rd_addr];
    end
  end

endmodule
